/* rtl/csvtok_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types, codes and constants of the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam int MAX_FIELDS_DEF = 64;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_FIELD  = 3'd1;
  localparam logic [2:0] KIND_RECORD = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_QUOTE    = 2'd1;
  localparam logic [1:0] ERR_COUNT    = 2'd2;
  localparam logic [1:0] ERR_TOO_MANY = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_out;
    logic [5:0]  field_number;
    logic        in_header;
    logic [1:0]  error_code;
    logic [15:0] record_total;
    logic        last_of_run;
  } result_t;

  function automatic result_t make_result(
    input logic [2:0]  kind,
    input logic [7:0]  data_out,
    input logic [5:0]  field_number,
    input logic        in_header,
    input logic [1:0]  error_code,
    input logic [15:0] record_total
  );
    result_t r;
    r.kind         = kind;
    r.data_out     = data_out;
    r.field_number = field_number;
    r.in_header    = in_header;
    r.error_code   = error_code;
    r.record_total = record_total;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/csv_record_tokenizer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csv_record_tokenizer_unit
// Streaming CSV tokenizer: one text byte in, data, field, record, error and
// text-end events out.
// ----------------------------------------------------------------------------
// Usage:
//   slave side takes one request per cycle while tready is high: tdata is
//   the text byte, tuser is the mode (0 text byte, 1 end of text). Master
//   side gives events: tuser is the event kind, tdata the event fields,
//   tlast marks the final event of one input request.
//   Each input byte is decoded combinationally into zero, one or two events
//   held in a two-entry output buffer; events appear in the cycle after the
//   request. Throughput: one byte per cycle while each byte makes at most
//   one event and the receiver takes every event; a byte that makes two events
//   (a held CR flushed together with the next byte, or a line close followed
//   by text end) holds the next byte off until its first event has drained.
//   When the receiver stalls, tready drops as soon as the buffer cannot take
//   the events of a new byte; nothing is lost or reordered.
//   Reset clears the parser state and the output buffer; end of text also
//   returns the parser to its reset state for the next text.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_unit #(
  parameter int MAX_FIELDS = csvtok_pkg::MAX_FIELDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte
  input  wire logic        s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // data_out[7:0], field_number[13:8], in_header[14], error_code[16:15],
  // record_total[32:17], zero fill[39:33]
  output logic [39:0]      m_tdata,
  output logic [2:0]       m_tuser,   // kind
  output logic             m_tlast    // last_of_run
);

  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam logic [FW-1:0] FIELD_LAST = FW'(MAX_FIELDS - 1);
  localparam logic [FW-1:0] FIELD_ONE  = FW'(1);

  // parser state
  logic          inside_quotes, inside_quotes_next;
  logic          quote_pend, quote_pend_next;
  logic          cr_pend, cr_pend_next;
  logic          line_content, line_content_next;
  logic [FW-1:0] cur_field, cur_field_next;
  logic [FW-1:0] hdr_count, hdr_count_next;
  logic          hdr_done, hdr_done_next;
  logic          err_latched, err_latched_next;
  logic [1:0]    err_kind, err_kind_next;
  logic [15:0]   rec_count, rec_count_next;

  // output buffer
  logic [1:0]          buf_cnt;
  csvtok_pkg::result_t slot0, slot1;

  // events of the current request
  logic [1:0]          ev_cnt;
  csvtok_pkg::result_t ev0, ev1, ev;

  logic       accept, pop;
  logic       hdr_flag;
  logic [5:0] fnum;
  logic [7:0] b;

  assign m_tvalid = (buf_cnt != 2'd0);
  assign pop      = m_tvalid & m_tready;
  assign s_tready = (buf_cnt == 2'd0) | ((buf_cnt == 2'd1) & m_tready);
  assign accept   = s_tvalid & s_tready;

  assign m_tuser = slot0.kind;
  assign m_tlast = slot0.last_of_run;
  assign m_tdata = {7'd0, slot0.record_total, slot0.error_code, slot0.in_header,
                    slot0.field_number, slot0.data_out};

  assign b = s_tdata;

  always_comb begin
    inside_quotes_next = inside_quotes;
    quote_pend_next    = quote_pend;
    cr_pend_next       = cr_pend;
    line_content_next  = line_content;
    cur_field_next     = cur_field;
    hdr_count_next     = hdr_count;
    hdr_done_next      = hdr_done;
    err_latched_next   = err_latched;
    err_kind_next      = err_kind;
    rec_count_next     = rec_count;
    ev_cnt   = 2'd0;
    ev0      = '0;
    ev1      = '0;
    ev       = '0;
    hdr_flag = ~hdr_done;
    fnum     = 6'(cur_field);

    if (s_tuser || (!err_latched && b == csvtok_pkg::CH_LF)) begin
      // line close, on LF or at end of text
      if (!err_latched && (s_tuser == 1'b0 || line_content || cr_pend)) begin
        if (quote_pend) begin
          inside_quotes_next = 1'b0;
        end
        if (hdr_done && !line_content) begin
          ev_cnt = 2'd0;
        end else if (quote_pend ? 1'b0 : inside_quotes) begin
          err_latched_next = 1'b1;
          err_kind_next    = csvtok_pkg::ERR_QUOTE;
          ev0 = csvtok_pkg::make_result(csvtok_pkg::KIND_ERROR, 8'd0, fnum, hdr_flag,
                                        csvtok_pkg::ERR_QUOTE, 16'd0);
          ev_cnt = 2'd1;
        end else if (!hdr_done) begin
          hdr_count_next = FW'(cur_field + FIELD_ONE);
          hdr_done_next  = 1'b1;
          ev0 = csvtok_pkg::make_result(csvtok_pkg::KIND_RECORD, 8'd0, fnum, 1'b1,
                                        csvtok_pkg::ERR_NONE, 16'd0);
          ev_cnt = 2'd1;
        end else if (FW'(cur_field + FIELD_ONE) != hdr_count) begin
          err_latched_next = 1'b1;
          err_kind_next    = csvtok_pkg::ERR_COUNT;
          ev0 = csvtok_pkg::make_result(csvtok_pkg::KIND_ERROR, 8'd0, fnum, 1'b0,
                                        csvtok_pkg::ERR_COUNT, 16'd0);
          ev_cnt = 2'd1;
        end else begin
          if (rec_count != csvtok_pkg::TOTAL_MAX) begin
            rec_count_next = rec_count + 16'd1;
          end
          ev0 = csvtok_pkg::make_result(csvtok_pkg::KIND_RECORD, 8'd0, fnum, 1'b0,
                                        csvtok_pkg::ERR_NONE, 16'd0);
          ev_cnt = 2'd1;
        end
        inside_quotes_next = 1'b0;
        quote_pend_next    = 1'b0;
        cr_pend_next       = 1'b0;
        line_content_next  = 1'b0;
        cur_field_next     = '0;
      end
      if (s_tuser) begin
        ev = csvtok_pkg::make_result(csvtok_pkg::KIND_END, 8'd0, 6'd0, 1'b0,
                                     err_latched_next ? err_kind_next
                                                      : csvtok_pkg::ERR_NONE,
                                     rec_count_next);
        if (ev_cnt == 2'd0) begin
          ev0 = ev;
        end else begin
          ev1 = ev;
        end
        ev_cnt = ev_cnt + 2'd1;
        // back to reset state for the next text
        inside_quotes_next = 1'b0;
        quote_pend_next    = 1'b0;
        cr_pend_next       = 1'b0;
        line_content_next  = 1'b0;
        cur_field_next     = '0;
        hdr_count_next     = '0;
        hdr_done_next      = 1'b0;
        err_latched_next   = 1'b0;
        err_kind_next      = csvtok_pkg::ERR_NONE;
        rec_count_next     = '0;
      end
    end else if (!err_latched) begin
      // flush of a held cr as data
      if (cr_pend) begin
        ev0 = csvtok_pkg::make_result(csvtok_pkg::KIND_DATA, csvtok_pkg::CH_CR, fnum,
                                      hdr_flag, csvtok_pkg::ERR_NONE, 16'd0);
        ev_cnt = 2'd1;
        line_content_next = 1'b1;
      end
      ev = '0;
      if (b == csvtok_pkg::CH_CR) begin
        if (quote_pend) begin
          quote_pend_next    = 1'b0;
          inside_quotes_next = 1'b0;
        end
        cr_pend_next = 1'b1;
      end else begin
        cr_pend_next      = 1'b0;
        line_content_next = 1'b1;
        if (quote_pend) begin
          quote_pend_next    = 1'b0;
          inside_quotes_next = 1'b0;
        end
        if (quote_pend && b == csvtok_pkg::CH_QUOTE) begin
          // doubled quote inside quotes
          inside_quotes_next = inside_quotes;
          ev = csvtok_pkg::make_result(csvtok_pkg::KIND_DATA, csvtok_pkg::CH_QUOTE, fnum,
                                       hdr_flag, csvtok_pkg::ERR_NONE, 16'd0);
          ev.last_of_run = 1'b1;
        end else if (b == csvtok_pkg::CH_QUOTE) begin
          if (inside_quotes_next) begin
            quote_pend_next = 1'b1;
          end else begin
            inside_quotes_next = 1'b1;
          end
        end else if (b == csvtok_pkg::CH_COMMA && !inside_quotes_next) begin
          if (cur_field == FIELD_LAST) begin
            err_latched_next = 1'b1;
            err_kind_next    = csvtok_pkg::ERR_TOO_MANY;
            ev = csvtok_pkg::make_result(csvtok_pkg::KIND_ERROR, 8'd0, fnum, hdr_flag,
                                         csvtok_pkg::ERR_TOO_MANY, 16'd0);
          end else begin
            cur_field_next = FW'(cur_field + FIELD_ONE);
            ev = csvtok_pkg::make_result(csvtok_pkg::KIND_FIELD, 8'd0, fnum, hdr_flag,
                                         csvtok_pkg::ERR_NONE, 16'd0);
          end
          ev.last_of_run = 1'b1;
        end else begin
          ev = csvtok_pkg::make_result(csvtok_pkg::KIND_DATA, b, fnum, hdr_flag,
                                       csvtok_pkg::ERR_NONE, 16'd0);
          ev.last_of_run = 1'b1;
        end
        // last_of_run used here only as an event-present mark
        if (ev.last_of_run) begin
          ev.last_of_run = 1'b0;
          if (ev_cnt == 2'd0) begin
            ev0 = ev;
          end else begin
            ev1 = ev;
          end
          ev_cnt = ev_cnt + 2'd1;
        end
      end
    end

    if (ev_cnt == 2'd1) begin
      ev0.last_of_run = 1'b1;
    end else if (ev_cnt == 2'd2) begin
      ev1.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes <= 1'b0;
      quote_pend    <= 1'b0;
      cr_pend       <= 1'b0;
      line_content  <= 1'b0;
      cur_field     <= '0;
      hdr_count     <= '0;
      hdr_done      <= 1'b0;
      err_latched   <= 1'b0;
      err_kind      <= csvtok_pkg::ERR_NONE;
      rec_count     <= '0;
      buf_cnt       <= 2'd0;
    end else begin
      if (accept) begin
        inside_quotes <= inside_quotes_next;
        quote_pend    <= quote_pend_next;
        cr_pend       <= cr_pend_next;
        line_content  <= line_content_next;
        cur_field     <= cur_field_next;
        hdr_count     <= hdr_count_next;
        hdr_done      <= hdr_done_next;
        err_latched   <= err_latched_next;
        err_kind      <= err_kind_next;
        rec_count     <= rec_count_next;
        buf_cnt       <= ev_cnt;
      end else if (pop) begin
        buf_cnt <= buf_cnt - 2'd1;
      end
    end
  end

  // event buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= ev0;
      slot1 <= ev1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csv_record_tokenizer_unit. A short scripted part
// covers empty text, an empty header, extreme bytes, held CR, skipped blank
// lines, quote handling and the open-quote and field-count errors. Random
// CSV texts follow. Every request also runs through a behavioral tokenizer
// in the bench; each event is compared field by field against the oldest
// predicted event. Both sides idle at random, and the receiver holds off
// once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import csvtok_pkg::*;

  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam int FIELD_LIMIT     = MAX_FIELDS_DEF;
  localparam int RANDOM_REQUESTS = 450;
  localparam int HOLD_CYCLES     = 40;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [5:0]  fld;
    logic        hdr;
    logic [1:0]  err;
    logic [15:0] total;
  } typed_event_t;

  typedef struct packed {
    logic         mode;
    logic [7:0]   ch;
    logic         fixed;
    typed_event_t want;
  } script_row_t;

  localparam typed_event_t NO_EVENT = '0;
  localparam int SCRIPT_LEN = 30;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty text
    '{MODE_END,  8'h00,    1'b1, '{KIND_END,    8'h00, 6'd0, 1'b0, ERR_NONE,  16'd0}},
    // empty header, extremes, held cr, blank line, wide row
    '{MODE_TEXT, CH_LF,    1'b1, '{KIND_RECORD, 8'h00, 6'd0, 1'b1, ERR_NONE,  16'd0}},
    '{MODE_TEXT, 8'hFF,    1'b1, '{KIND_DATA,   8'hFF, 6'd0, 1'b0, ERR_NONE,  16'd0}},
    '{MODE_TEXT, CH_CR,    1'b0, NO_EVENT},
    '{MODE_TEXT, 8'h00,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_LF,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_LF,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_COMMA, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_LF,    1'b1, '{KIND_ERROR,  8'h00, 6'd1, 1'b0, ERR_COUNT, 16'd0}},
    '{MODE_TEXT, 8'h6B,    1'b0, NO_EVENT},
    '{MODE_END,  8'hFF,    1'b1, '{KIND_END,    8'h00, 6'd0, 1'b0, ERR_COUNT, 16'd1}},
    // doubled quote, comma inside quotes, open quote at line end
    '{MODE_TEXT, CH_QUOTE, 1'b0, NO_EVENT},
    '{MODE_TEXT, 8'h78,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_QUOTE, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_QUOTE, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_COMMA, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_CR,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_LF,    1'b1, '{KIND_ERROR,  8'h00, 6'd0, 1'b1, ERR_QUOTE, 16'd0}},
    '{MODE_END,  8'h00,    1'b1, '{KIND_END,    8'h00, 6'd0, 1'b0, ERR_QUOTE, 16'd0}},
    // quote closed by cr lf, last line without lf
    '{MODE_TEXT, 8'h61,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_COMMA, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_QUOTE, 1'b0, NO_EVENT},
    '{MODE_TEXT, 8'h62,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_QUOTE, 1'b0, NO_EVENT},
    '{MODE_TEXT, CH_CR,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_LF,    1'b0, NO_EVENT},
    '{MODE_TEXT, 8'h63,    1'b0, NO_EVENT},
    '{MODE_TEXT, CH_COMMA, 1'b0, NO_EVENT},
    '{MODE_TEXT, 8'h64,    1'b0, NO_EVENT},
    '{MODE_END,  8'h00,    1'b0, NO_EVENT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = MODE_TEXT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  csv_record_tokenizer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tokenizer state mirrored in the bench
  bit          in_quotes, quote_held, cr_held, line_used, header_seen, err_latched;
  int unsigned cur_field, header_fields;
  logic [1:0]  err_kind;
  logic [15:0] record_count;

  result_t step_events[$];
  result_t expected_events[$];
  result_t want_ev;

  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int mismatches = 0;
  int events_checked = 0;
  int sent_requests = 0;
  int texts_done = 0;
  int quote_errors = 0;
  int count_errors = 0;
  int wide_errors = 0;
  int cycle_count = 0;

  function automatic void push_event(logic [2:0] kind, logic [7:0] data, logic [5:0] fld,
                                     logic hdr, logic [1:0] err, logic [15:0] total);
    result_t ev;
    ev.kind         = kind;
    ev.data_out     = data;
    ev.field_number = fld;
    ev.in_header    = hdr;
    ev.error_code   = err;
    ev.record_total = total;
    ev.last_of_run  = 1'b0;
    step_events = {step_events, ev};
  endfunction

  function automatic void line_event(logic [2:0] kind, logic [7:0] data, logic [1:0] err);
    push_event(kind, data, 6'(cur_field), !header_seen, err, 16'd0);
  endfunction

  function automatic void clear_line_state();
    in_quotes  = 1'b0;
    quote_held = 1'b0;
    cr_held    = 1'b0;
    line_used  = 1'b0;
    cur_field  = 0;
  endfunction

  function automatic void latch_error(logic [1:0] code);
    err_latched = 1'b1;
    err_kind    = code;
    line_event(KIND_ERROR, 8'h00, code);
    case (code)
      ERR_QUOTE: quote_errors++;
      ERR_COUNT: count_errors++;
      default:   wide_errors++;
    endcase
  endfunction

  function automatic void release_cr();
    if (cr_held) begin
      cr_held   = 1'b0;
      line_used = 1'b1;
      line_event(KIND_DATA, CH_CR, ERR_NONE);
    end
  endfunction

  function automatic void close_line();
    cr_held = 1'b0;
    if (quote_held) begin
      quote_held = 1'b0;
      in_quotes  = 1'b0;
    end
    if (header_seen && !line_used) begin
      // blank data line
    end else if (in_quotes) begin
      latch_error(ERR_QUOTE);
    end else if (!header_seen) begin
      line_event(KIND_RECORD, 8'h00, ERR_NONE);
      header_fields = cur_field + 1;
      header_seen   = 1'b1;
    end else if (cur_field + 1 != header_fields) begin
      latch_error(ERR_COUNT);
    end else begin
      if (record_count != TOTAL_MAX) record_count++;
      line_event(KIND_RECORD, 8'h00, ERR_NONE);
    end
    clear_line_state();
  endfunction

  function automatic void take_text_byte(logic [7:0] b);
    if (b == CH_CR) begin
      if (quote_held) begin
        quote_held = 1'b0;
        in_quotes  = 1'b0;
      end
      release_cr();
      cr_held = 1'b1;
      return;
    end
    release_cr();
    line_used = 1'b1;
    if (quote_held) begin
      quote_held = 1'b0;
      if (b == CH_QUOTE) begin
        line_event(KIND_DATA, CH_QUOTE, ERR_NONE);
        return;
      end
      in_quotes = 1'b0;
    end
    if (b == CH_QUOTE) begin
      if (in_quotes) quote_held = 1'b1;
      else in_quotes = 1'b1;
    end else if (b == CH_COMMA && !in_quotes) begin
      if (cur_field + 1 >= FIELD_LIMIT) begin
        latch_error(ERR_TOO_MANY);
      end else begin
        line_event(KIND_FIELD, 8'h00, ERR_NONE);
        cur_field++;
      end
    end else begin
      line_event(KIND_DATA, b, ERR_NONE);
    end
  endfunction

  function automatic void tokenize(logic mode, logic [7:0] b);
    step_events.delete();
    if (mode == MODE_END) begin
      if (!err_latched && (line_used || cr_held)) close_line();
      push_event(KIND_END, 8'h00, 6'd0, 1'b0, err_latched ? err_kind : ERR_NONE, record_count);
      clear_line_state();
      header_fields = 0;
      header_seen   = 1'b0;
      err_latched   = 1'b0;
      err_kind      = ERR_NONE;
      record_count  = 16'd0;
      texts_done++;
    end else if (!err_latched) begin
      if (b == CH_LF) close_line();
      else take_text_byte(b);
    end
  endfunction

  function automatic void commit_step();
    foreach (step_events[i]) begin
      if (i == step_events.size() - 1) step_events[i].last_of_run = 1'b1;
      expected_events = {expected_events, step_events[i]};
    end
  endfunction

  task automatic offer(input logic mode, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent_requests++;
  endtask

  task automatic put(input logic [7:0] b);
    offer(MODE_TEXT, b);
    tokenize(MODE_TEXT, b);
    commit_step();
  endtask

  task automatic put_end();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    offer(MODE_END, b);
    tokenize(MODE_END, b);
    commit_step();
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task automatic send_field(input int maxlen);
    int pick;
    int len;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      len = $urandom_range(0, maxlen);
      repeat (len) put(plain_char());
    end else if (pick < 19) begin
      put(CH_QUOTE);
      len = $urandom_range(0, maxlen + 1);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: put(CH_COMMA);
          1: begin
            put(CH_QUOTE);
            put(CH_QUOTE);
          end
          2: put(CH_CR);
          default: put(plain_char());
        endcase
      end
      // now and then the quote stays open
      if ($urandom_range(0, 15) != 0) put(CH_QUOTE);
      if ($urandom_range(0, 5) == 0) put(plain_char());
    end else begin
      put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_row(input int nf, input int maxlen);
    for (int i = 0; i < nf; i++) begin
      send_field(maxlen);
      if (i < nf - 1) put(CH_COMMA);
    end
  endtask

  task automatic end_row();
    if ($urandom_range(0, 2) == 0) put(CH_CR);
    put(CH_LF);
  endtask

  task automatic random_text();
    int nf;
    int rows;
    int shape;
    if ($urandom_range(0, 9) == 0) begin
      put_end();
      return;
    end
    nf = $urandom_range(1, 6);
    send_row(nf, 4);
    end_row();
    rows = $urandom_range(0, 5);
    for (int r = 0; r < rows; r++) begin
      shape = $urandom_range(0, 11);
      if (shape == 1) send_row(nf > 1 ? nf - 1 : nf + 1, 4);
      else if (shape != 0) send_row(nf, 4);
      if (r < rows - 1 || $urandom_range(0, 2) != 0) end_row();
    end
    if ($urandom_range(0, 7) == 0) put(CH_CR);
    put_end();
  endtask

  // widest legal header, then a data row one field too wide
  task automatic wide_text();
    send_row(FIELD_LIMIT, 0);
    end_row();
    send_row(FIELD_LIMIT + 1, 0);
    end_row();
    put_end();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("event %0d: %s expected %0h, got %0h", events_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected event: kind %0d tdata %0h last %0b", m_tuser, m_tdata, m_tlast);
      end else begin
        want_ev = expected_events.pop_front();
        check_field("kind", want_ev.kind, m_tuser);
        check_field("data_out", want_ev.data_out, m_tdata[7:0]);
        check_field("field_number", want_ev.field_number, m_tdata[13:8]);
        check_field("in_header", want_ev.in_header, m_tdata[14]);
        check_field("error_code", want_ev.error_code, m_tdata[16:15]);
        check_field("record_total", want_ev.record_total, m_tdata[32:17]);
        check_field("zero fill", 0, m_tdata[39:33]);
        check_field("last_of_run", want_ev.last_of_run, m_tlast);
        events_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d events outstanding", expected_events.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : event_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : request_source
    result_t typed_ev;
    int text_no;
    err_kind     = ERR_NONE;
    record_count = 16'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      offer(SCRIPT[i].mode, SCRIPT[i].ch);
      tokenize(SCRIPT[i].mode, SCRIPT[i].ch);
      if (SCRIPT[i].fixed) begin
        typed_ev.kind         = SCRIPT[i].want.kind;
        typed_ev.data_out     = SCRIPT[i].want.data;
        typed_ev.field_number = SCRIPT[i].want.fld;
        typed_ev.in_header    = SCRIPT[i].want.hdr;
        typed_ev.error_code   = SCRIPT[i].want.err;
        typed_ev.record_total = SCRIPT[i].want.total;
        typed_ev.last_of_run  = 1'b0;
        step_events = {typed_ev};
      end
      commit_step();
    end

    text_no = 0;
    while (sent_requests < RANDOM_REQUESTS) begin
      idle_on = (text_no % 4 != 3);
      if (text_no == 3) hold_off_req = 1'b1;
      if (text_no == 1) wide_text();
      else random_text();
      text_no++;
    end
    s_tvalid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d texts, %0d requests sent, %0d events checked",
             texts_done, sent_requests, events_checked);
    $display("errors raised: open quote %0d, field count %0d, too many fields %0d",
             quote_errors, count_errors, wide_errors);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* csv_record_tokenizer_unit.f */
rtl/csvtok_pkg.sv
rtl/csv_record_tokenizer_unit.sv
tb/sv/tb.sv
